// ===== hdl/lts_pkg.sv =====
// Package with shared types, constants and the helper function of the lottery task scheduler.
package lts_pkg;

	localparam int TaskSlotsDef  = 16;
	localparam int TicketBitsDef = 16;
	localparam logic [15:0] TimeCreditReset = 16'd20001;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_ZERO     = 3'd2,
		ST_NOSPACE  = 3'd3,
		ST_RAN      = 3'd4,
		ST_MISS     = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	typedef enum logic {
		FN_ADD  = 1'b0,
		FN_DRAW = 1'b1
	} func_t;

	typedef struct packed {
		logic        func;
		logic [15:0] task_id;
		logic [15:0] quanta;
		logic [5:0]  ticket_count;
		logic [31:0] random_word;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] winner_id;
		logic        task_finished;
		logic [15:0] drawn_ticket;
		logic [47:0] class_time_total;
		logic [31:0] class_add_total;
	} result_t;

	// Priority class of a ticket count; valid bit in msb.
	function automatic logic [2:0] class_of(input logic [5:0] prio);
		logic [2:0] c;
		begin
			unique case (prio)
				6'd20:   c = 3'b100;
				6'd10:   c = 3'b101;
				6'd5:    c = 3'b110;
				6'd1:    c = 3'b111;
				default: c = 3'b000;
			endcase
			return c;
		end
	endfunction

endpackage

// ===== hdl/lts_queue.sv =====
// Short two-entry queue between the front and the back of the scheduler.
module lts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lts_pkg::item_t push_data,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output lts_pkg::item_t pop_data
);
	import lts_pkg::*;

	item_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop_data  = mem_q[rd_ptr_q];
endmodule

// ===== hdl/lts_engine.sv =====
// Back end of the scheduler: modulo reduction, slot search and table update.
module lts_engine #(
	parameter int TASK_SLOTS  = lts_pkg::TaskSlotsDef,
	parameter int TICKET_BITS = lts_pkg::TicketBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      time_credit,
	input  logic             item_valid,
	input  lts_pkg::item_t   item,
	output logic             item_pop,
	output logic             result_valid,
	output lts_pkg::result_t result
);
	import lts_pkg::*;

	localparam int SW = $clog2(TASK_SLOTS);
	localparam int LW = $clog2(TASK_SLOTS + 1);
	localparam int RB = 32;
	localparam int CW = $clog2(RB + 1);

	typedef enum logic [2:0] {S_IDLE, S_ADD, S_MOD, S_SCAN, S_FIN} state_t;

	state_t                 state_q;
	item_t                  cur_q;
	logic [TASK_SLOTS-1:0]  valid_q;
	logic [15:0]            id_mem  [TASK_SLOTS];
	logic [15:0]            qnt_mem [TASK_SLOTS];
	logic [TICKET_BITS-1:0] base_mem[TASK_SLOTS];
	logic [5:0]             span_mem[TASK_SLOTS];
	logic [TICKET_BITS-1:0] issued_q;
	logic [LW-1:0]          live_q;
	logic [31:0]            adds_q [4];
	logic [47:0]            time_q [4];
	logic [SW:0]            idx_q;
	logic [SW-1:0]          free_q;
	logic                   free_ok_q;
	logic [TICKET_BITS-1:0] rem_q;
	logic [31:0]            quo_q;
	logic [CW-1:0]          bit_q;
	result_t                res_q;
	logic                   rv_q;

	logic [TICKET_BITS:0]   rem_sh;
	logic [TICKET_BITS:0]   rem_sub;
	logic [SW-1:0]          idx;
	logic [2:0]             cls_add;
	logic [2:0]             cls_win;
	logic [TICKET_BITS:0]   hi_w;
	logic                   hit;
	logic [TICKET_BITS:0]   sum_w;

	assign idx     = idx_q[SW-1:0];
	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, issued_q};
	assign cls_add = class_of(cur_q.ticket_count);
	assign cls_win = class_of(span_mem[idx]);
	assign hi_w    = {1'b0, base_mem[idx]} + (TICKET_BITS+1)'(span_mem[idx]);
	assign hit     = valid_q[idx] && ({1'b0, rem_q} >= {1'b0, base_mem[idx]})
		&& ({1'b0, rem_q} < hi_w);
	assign sum_w   = {1'b0, issued_q} + (TICKET_BITS+1)'(cur_q.ticket_count);
	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign result_valid = rv_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_ADD && idx_q == (SW+1)'(TASK_SLOTS) && free_ok_q &&
			!(sum_w > {1'b0, {TICKET_BITS{1'b1}}})) begin
			id_mem[free_q]   <= cur_q.task_id;
			qnt_mem[free_q]  <= cur_q.quanta;
			base_mem[free_q] <= issued_q;
			span_mem[free_q] <= cur_q.ticket_count;
		end else if (state_q == S_SCAN && idx_q < (SW+1)'(TASK_SLOTS) && hit) begin
			qnt_mem[idx] <= qnt_mem[idx] - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			issued_q  <= '0;
			live_q    <= '0;
			for (int k = 0; k < 4; k++) begin
				adds_q[k] <= '0;
				time_q[k] <= '0;
			end
			idx_q     <= '0;
			free_q    <= '0;
			free_ok_q <= 1'b0;
			rem_q     <= '0;
			quo_q     <= '0;
			bit_q     <= '0;
			rv_q      <= 1'b0;
			res_q     <= '0;
			cur_q     <= '0;
		end else begin
			rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cur_q     <= item;
						idx_q     <= '0;
						free_ok_q <= 1'b0;
						rem_q     <= '0;
						quo_q     <= item.random_word;
						bit_q     <= '0;
						if (item.func == FN_ADD) begin
							if (item.ticket_count == 6'd0 || item.quanta == 16'd0) begin
								res_q <= '{status: ST_ZERO, default: '0};
								rv_q <= 1'b1;
							end else begin
								res_q   <= '0;
								state_q <= S_ADD;
							end
						end else if (live_q == '0 || issued_q == '0) begin
							res_q <= '{status: ST_EMPTY, default: '0};
							rv_q <= 1'b1;
						end else begin
							res_q   <= '0;
							state_q <= S_MOD;
						end
					end
				end
				S_ADD: begin
					// One slot a cycle looking for the lowest free one.
					if (idx_q < (SW+1)'(TASK_SLOTS)) begin
						if (!valid_q[idx] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= idx;
						end
						idx_q <= idx_q + (SW+1)'(1);
					end else begin
						state_q <= S_IDLE;
						rv_q    <= 1'b1;
						if (!free_ok_q) begin
							res_q.status <= ST_FULL;
						end else if (sum_w > {1'b0, {TICKET_BITS{1'b1}}}) begin
							res_q.status <= ST_NOSPACE;
						end else begin
							res_q.status   <= ST_ADDED;
							valid_q[free_q] <= 1'b1;
							issued_q       <= sum_w[TICKET_BITS-1:0];
							live_q         <= live_q + LW'(1);
							if (cls_add[2]) begin
								adds_q[cls_add[1:0]] <= adds_q[cls_add[1:0]] + 32'd1;
								res_q.class_add_total <= adds_q[cls_add[1:0]] + 32'd1;
							end
						end
					end
				end
				S_MOD: begin
					// Restoring division, one quotient bit a cycle.
					quo_q <= {quo_q[30:0], 1'b0};
					if (rem_sh >= {1'b0, issued_q}) begin
						rem_q <= rem_sub[TICKET_BITS-1:0];
					end else begin
						rem_q <= rem_sh[TICKET_BITS-1:0];
					end
					bit_q <= bit_q + CW'(1);
					if (bit_q == CW'(RB - 1)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					res_q.drawn_ticket <= 16'(rem_q);
					if (idx_q < (SW+1)'(TASK_SLOTS) && hit) begin
						state_q <= S_IDLE;
						rv_q    <= 1'b1;
						res_q.status    <= ST_RAN;
						res_q.winner_id <= id_mem[idx];
						if (cls_win[2]) begin
							time_q[cls_win[1:0]] <= time_q[cls_win[1:0]] + 48'(time_credit);
							res_q.class_time_total <= time_q[cls_win[1:0]] + 48'(time_credit);
							res_q.class_add_total  <= adds_q[cls_win[1:0]];
						end
						if (qnt_mem[idx] == 16'd1) begin
							valid_q[idx] <= 1'b0;
							live_q <= live_q - LW'(1);
							res_q.task_finished <= 1'b1;
						end
					end else if (idx_q < (SW+1)'(TASK_SLOTS)) begin
						idx_q <= idx_q + (SW+1)'(1);
					end else begin
						state_q <= S_IDLE;
						rv_q    <= 1'b1;
						res_q.status <= ST_MISS;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/lottery_task_scheduler.sv =====
// Top level of the lottery task scheduler: front end, item queue and engine.
//
// Items are accepted when start is high and busy is low; the front end
// places each transfer into a two-entry queue and busy rises only when the
// queue is full. The engine takes one item at a time: an add with zero
// tickets or zero quanta, or a draw on an empty table, answers in the cycle
// after it is dequeued, an add scans the slot table one slot a cycle, and a
// draw passes through the one-bit-per-cycle modulo unit and then scans the
// slots for the ticket owner. Each result shows on result for exactly one
// cycle with done high; the receiver cannot hold it off, so it must take
// every transfer when it appears.
module lottery_task_scheduler #(
	parameter int TASK_SLOTS  = lts_pkg::TaskSlotsDef,
	parameter int TICKET_BITS = lts_pkg::TicketBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lts_pkg::item_t   item,
	output logic             done,
	output lts_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata
);
	import lts_pkg::*;

	logic [15:0] credit_q;
	logic        q_full;
	logic        q_ne;
	logic        q_pop;
	item_t       q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= TimeCreditReset;
		end else if (cfg_we) begin
			credit_q <= cfg_wdata;
		end
	end

	assign busy = q_full;

	lts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start && !q_full),
		.push_data (item),
		.pop       (q_pop),
		.not_empty (q_ne),
		.full      (q_full),
		.pop_data  (q_data)
	);

	lts_engine #(
		.TASK_SLOTS  (TASK_SLOTS),
		.TICKET_BITS (TICKET_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_credit  (credit_q),
		.item_valid   (q_ne),
		.item         (q_data),
		.item_pop     (q_pop),
		.result_valid (done),
		.result       (result)
	);

	// A result only reports a winner when the status says one ran.
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_RAN |-> result.winner_id == 16'd0)
		else $error("winner id on non-run result");
	// Finishing a task only happens on a run.
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.task_finished |-> result.status == ST_RAN)
		else $error("finish flag without a run");
	// A full queue stays full until the engine takes an entry.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> q_full)
		else $error("queue lost its full state without a pop");
endmodule
